// ===== src/sorted_byte_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_byte_table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_BYTE_TABLE_MACROS_SVH
`define SORTED_BYTE_TABLE_MACROS_SVH

// Same-cycle implication.
`define SBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Constants, types and command codes shared by the sorted byte table.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 8;
  localparam int COUNT_OUT_W = 7;

  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [COUNT_OUT_W-1:0] cnt_out_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  // Table RAM access for one cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // One finished command result
  typedef struct packed {
    logic     valid;
    logic     success;
    cnt_out_t count;
    data_t    largest;
    logic     is_empty;
  } result_t;

endpackage

// ===== src/sbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sbt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_ctrl
// Command sequencer: walks the table RAM to insert or remove entries; clear zeroes the count.
// ----------------------------------------------------------------------------
module sbt_ctrl import sbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  logic [1:0] cmd_action,
  input  data_t    cmd_value,
  input  logic     slot_free,
  output result_t  res,
  output ram_req_t ram_req,
  input  data_t    ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_CMP,
    S_REM_SHF,
    S_LAST_RD,
    S_LAST_CAP,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    count_r, count_nxt;
  cnt_t    idx_r, idx_nxt;
  data_t   val_r, val_nxt;
  logic    ok_r, ok_nxt;
  data_t   largest_r, largest_nxt;
  logic    res_valid_r, res_valid_nxt;

  cnt_t    idx_dn1, idx_dn2, idx_up1, idx_up2, cnt_dn1;
  logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

  assign idx_dn1 = cnt_t'(idx_r - 1'b1);
  assign idx_dn2 = cnt_t'(idx_r - 2'd2);
  assign idx_up1 = cnt_t'(idx_r + 1'b1);
  assign idx_up2 = cnt_t'(idx_r + 2'd2);
  assign cnt_dn1 = cnt_t'(count_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    largest_nxt   = largest_r;
    res_valid_nxt = 1'b0;
    ram_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          val_nxt   = cmd_value;
          ok_nxt    = 1'b0;
          state_nxt = S_LAST_RD;
          case (cmd_action)
            ACT_INSERT: begin
              if (count_r == cnt_t'(0)) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = cmd_value;
                count_nxt     = cnt_t'(count_r + 1'b1);
                ok_nxt        = 1'b1;
              end else if (count_r < cnt_t'(CAPACITY)) begin
                // start at the top; shift larger-or-equal entries up one
                ram_req.re    = 1'b1;
                ram_req.raddr = cnt_dn1[ADDR_W-1:0];
                idx_nxt       = count_r;
                state_nxt     = S_INS_CMP;
              end
            end
            ACT_REMOVE: begin
              if (count_r != cnt_t'(0)) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                idx_nxt       = '0;
                state_nxt     = S_REM_CMP;
              end
            end
            ACT_CLEAR: begin
              if (count_r != cnt_t'(0)) begin
                count_nxt = '0;
                ok_nxt    = 1'b1;
              end
            end
            default: begin
              // unused code: report unchanged table
            end
          endcase
        end
      end

      // ram_rdata holds entry idx-1
      S_INS_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[ADDR_W-1:0];
        if (ram_rdata >= val_r) begin
          ram_req.wdata = ram_rdata;
          idx_nxt       = idx_dn1;
          if (idx_r == cnt_t'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_dn2[ADDR_W-1:0];
          end
        end else begin
          ram_req.wdata = val_r;
          count_nxt     = cnt_t'(count_r + 1'b1);
          ok_nxt        = 1'b1;
          state_nxt     = S_LAST_RD;
        end
      end

      S_INS_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[ADDR_W-1:0];
        ram_req.wdata = val_r;
        count_nxt     = cnt_t'(count_r + 1'b1);
        ok_nxt        = 1'b1;
        state_nxt     = S_LAST_RD;
      end

      // ram_rdata holds entry idx
      S_REM_CMP: begin
        if (ram_rdata < val_r) begin
          if (idx_up1 == count_r) begin
            state_nxt = S_LAST_RD;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_up1[ADDR_W-1:0];
            idx_nxt       = idx_up1;
          end
        end else if (ram_rdata != val_r) begin
          state_nxt = S_LAST_RD;
        end else begin
          ok_nxt = 1'b1;
          if (idx_up1 == count_r) begin
            count_nxt = cnt_dn1;
            state_nxt = S_LAST_RD;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_up1[ADDR_W-1:0];
            state_nxt     = S_REM_SHF;
          end
        end
      end

      // ram_rdata holds entry idx+1; move it down to idx
      S_REM_SHF: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        idx_nxt       = idx_up1;
        if (idx_up2 == count_r) begin
          count_nxt = cnt_dn1;
          state_nxt = S_LAST_RD;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_up2[ADDR_W-1:0];
        end
      end

      S_LAST_RD: begin
        if (count_r == cnt_t'(0)) begin
          largest_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cnt_dn1[ADDR_W-1:0];
          state_nxt     = S_LAST_CAP;
        end
      end

      S_LAST_CAP: begin
        largest_nxt = ram_rdata;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (slot_free) begin
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    ok_r      <= ok_nxt;
    largest_r <= largest_nxt;
  end

  assign count_wide   = {{COUNT_OUT_W{1'b0}}, count_r};
  assign cmd_ready    = (state_r == S_IDLE);
  assign res.valid    = res_valid_r;
  assign res.success  = ok_r;
  assign res.count    = count_wide[COUNT_OUT_W-1:0];
  assign res.largest  = largest_r;
  assign res.is_empty = (count_r == cnt_t'(0));

endmodule

// ===== src/sorted_byte_table.sv =====
`timescale 1ns / 1ps
// Sequence: accept, a table walk (insert into a nonempty, not full table, or remove),
//   a read of the largest entry unless the table ends empty, then the result handover.
// Throughput: one command at a time; a result stalled in the output register holds
//   the sequencer and the input.
// Reset (rst_n low, synchronous): count cleared, sequencer idle, output empty; RAM kept.
// ----------------------------------------------------------------------------
// sorted_byte_table
// Bounded ascending multiset of bytes with insert, remove and clear commands.
// ----------------------------------------------------------------------------
module sorted_byte_table import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] success, [7:1] count, [15:8] largest,
                                  // [16] is_empty, [23:17] zero
);

  ram_req_t ram_req;
  data_t    ram_rdata;
  result_t  res;
  logic     slot_free;

  logic     out_valid_r;
  logic     out_success_r;
  cnt_out_t out_count_r;
  data_t    out_largest_r;
  logic     out_empty_r;

  // Table storage: one entry written, one read per cycle
  sbt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Sequencer owns the count and walks the table for each command
  sbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd_ready  (in_tready),
    .cmd_action (in_tuser),
    .cmd_value  (in_tdata[DATA_W-1:0]),
    .slot_free  (slot_free),
    .res        (res),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  // Output holding register: the sequencer hands over a result only when
  // the register is empty or draining this cycle.
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    // load payload on handover, hold otherwise
    if (res.valid) begin
      out_success_r <= res.success;
      out_count_r   <= res.count;
      out_largest_r <= res.largest;
      out_empty_r   <= res.is_empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_empty_r, out_largest_r, out_count_r, out_success_r};

endmodule

// ===== src/sbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_checker
// Port-level checks on the sorted byte table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_byte_table_macros.svh"

module sbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // hold a stalled result
  `SBT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // one command at a time: no accept right after an accept
  `SBT_ASSERT_NEXT(a_one_cmd, in_tvalid && in_tready, !in_tready, "command taken while busy")

  // empty flag agrees with count
  `SBT_ASSERT_NOW(a_empty_cnt, out_tvalid, out_tdata[16] == (out_tdata[7:1] == 7'd0), "empty flag and count disagree")

  // empty table reports zero largest entry
  `SBT_ASSERT_NOW(a_empty_max, out_tvalid && out_tdata[16], out_tdata[15:8] == 8'd0, "empty table with nonzero largest")

endmodule

bind sorted_byte_table sbt_checker u_sbt_checker (.*);
